// ----- rtl/sgr_pkg.sv -----
// shared types and constants for the stream group reverser
`default_nettype none

package sgr_pkg;

   localparam int SGR_MAX_GROUP = 16;
   localparam int SGR_VALUE_W = 32;
   localparam int SGR_GSIZE_W = 5;
   localparam logic [SGR_GSIZE_W-1:0] SGR_GSIZE_RESET = 5'd2;

   typedef struct packed {
      logic signed [SGR_VALUE_W-1:0] in_value;
      logic                          in_last;
   } sgr_req_type;

   typedef struct packed {
      logic signed [SGR_VALUE_W-1:0] out_value;
      logic                          run_end;
      logic                          stream_end;
   } sgr_rsp_type;

   typedef enum logic [1:0] {
      SGR_IDLE,
      SGR_FETCH,
      SGR_SHOW
   } sgr_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic push;        // store request value, bump held count
      logic start;       // begin a run, load read pointer, clear held count
      logic reverse;     // run direction with start
      logic fetch;       // read store into output register, step pointer
      logic fin;         // with fetch: last result of the run
      logic stream_fin;  // with fetch: last result of the stream
   } sgr_cmd_type;

endpackage

`default_nettype wire

// ----- rtl/sgr_datapath.sv -----
// group store, held count, read pointer and output register
`default_nettype none

module sgr_datapath
   import sgr_pkg::*;
#(
   parameter int MAX_GROUP = SGR_MAX_GROUP
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire sgr_cmd_type                          cmd,
   input  wire sgr_req_type                          req_payload,
   output logic [$clog2(MAX_GROUP+1)-1:0]            held_count,
   output sgr_rsp_type                               rsp_payload
);

   localparam int CW = $clog2(MAX_GROUP + 1);
   localparam int IW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

   logic [SGR_VALUE_W-1:0] mem [MAX_GROUP];

   logic [CW-1:0]          held_ff, held_in;
   logic [IW-1:0]          ptr_ff, ptr_in;
   logic                   dir_ff, dir_in;
   logic [SGR_VALUE_W-1:0] rd_data_ff;
   logic                   run_end_ff;
   logic                   stream_end_ff;

   always_comb begin
      held_in = held_ff;
      ptr_in  = ptr_ff;
      dir_in  = dir_ff;
      if (cmd.start) begin
         held_in = '0;
         dir_in  = cmd.reverse;
         // newest entry sits at the old held count
         ptr_in  = cmd.reverse ? held_ff[IW-1:0] : '0;
      end else begin
         if (cmd.push) begin
            held_in = held_ff + CW'(1);
         end
         if (cmd.fetch) begin
            ptr_in = dir_ff ? (ptr_ff - IW'(1)) : (ptr_ff + IW'(1));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff <= '0;
      end else begin
         held_ff <= held_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      dir_ff <= dir_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.push) begin
         mem[held_ff[IW-1:0]] <= req_payload.in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.fetch) begin
         rd_data_ff    <= mem[ptr_ff];
         run_end_ff    <= cmd.fin;
         stream_end_ff <= cmd.stream_fin;
      end
   end

   assign held_count             = held_ff;
   assign rsp_payload.out_value  = rd_data_ff;
   assign rsp_payload.run_end    = run_end_ff;
   assign rsp_payload.stream_end = stream_end_ff;

endmodule

`default_nettype wire

// ----- rtl/sgr_controller.sv -----
// control state machine and group size register
`default_nettype none

module sgr_controller
   import sgr_pkg::*;
#(
   parameter int MAX_GROUP = SGR_MAX_GROUP
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   input  wire logic                          req_last,
   output logic                               req_stall,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   input  wire logic                          csr_wr_en,
   input  wire logic [SGR_GSIZE_W-1:0]        csr_wr_data,
   input  wire logic [$clog2(MAX_GROUP+1)-1:0] held_count,
   output sgr_cmd_type                        cmd
);

   localparam int CW = $clog2(MAX_GROUP + 1);

   sgr_state_type          state_ff, state_in;
   logic [SGR_GSIZE_W-1:0] gsize_ff;
   logic [CW-1:0]          remain_ff, remain_in;
   logic                   last_ff, last_in;
   logic [CW-1:0]          k_eff;
   logic [CW-1:0]          n_held;

   // clamp group size to 1..MAX_GROUP
   always_comb begin
      if (gsize_ff == '0) begin
         k_eff = CW'(1);
      end else if (int'(gsize_ff) > MAX_GROUP) begin
         k_eff = CW'(MAX_GROUP);
      end else begin
         k_eff = CW'(gsize_ff);
      end
   end

   assign n_held = held_count + CW'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= SGR_IDLE;
         gsize_ff  <= SGR_GSIZE_RESET;
         remain_ff <= '0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         remain_ff <= remain_in;
         last_ff   <= last_in;
         if (csr_wr_en) begin
            gsize_ff <= csr_wr_data;
         end
      end
   end

   always_comb begin
      state_in       = state_ff;
      remain_in      = remain_ff;
      last_in        = last_ff;
      cmd            = '0;
      req_stall      = 1'b1;
      rsp_valid      = 1'b0;
      unique case (state_ff)
         SGR_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.push = 1'b1;
               if (n_held >= k_eff) begin
                  cmd.start   = 1'b1;
                  cmd.reverse = 1'b1;
                  remain_in   = n_held;
                  last_in     = req_last;
                  state_in    = SGR_FETCH;
               end else if (req_last) begin
                  cmd.start   = 1'b1;
                  cmd.reverse = 1'b0;
                  remain_in   = n_held;
                  last_in     = 1'b1;
                  state_in    = SGR_FETCH;
               end
            end
         end
         SGR_FETCH: begin
            cmd.fetch      = 1'b1;
            cmd.fin        = (remain_ff == CW'(1));
            cmd.stream_fin = (remain_ff == CW'(1)) && last_ff;
            remain_in      = remain_ff - CW'(1);
            state_in       = SGR_SHOW;
         end
         SGR_SHOW: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = (remain_ff == '0) ? SGR_IDLE : SGR_FETCH;
            end
         end
         default: begin
            state_in = SGR_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_last |=> state_ff == SGR_FETCH)
      else $error("last request did not start a run");

   a_idle_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == SGR_IDLE |-> int'(held_count) < MAX_GROUP)
      else $error("group store full while idle");

   a_fetch_remain: assert property (@(posedge clock) disable iff (reset)
      state_ff == SGR_FETCH |-> remain_ff != '0)
      else $error("fetch with nothing left in the run");

   a_run_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.start |=> held_count == '0)
      else $error("held count not cleared at run start");
`endif

endmodule

`default_nettype wire

// ----- rtl/stream_group_reverser.sv -----
// top level: stream group reverser, reverses each full group of k requests;
//   a short tail at the end of a stream comes out in its original order
// throughput: one request a cycle while collecting; each result is read from the store
//   into the output register, and no request is taken until the run is delivered
// reset: synchronous, clears the controller, held count and group size (to 2);
//   the group store itself is not cleared, only written entries are ever read
`default_nettype none

module stream_group_reverser
   import sgr_pkg::*;
#(
   parameter int MAX_GROUP = SGR_MAX_GROUP
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire sgr_req_type            req_payload,
   // result channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output sgr_rsp_type                 rsp_payload,
   // group size register
   input  wire logic                   csr_wr_en,
   input  wire logic [SGR_GSIZE_W-1:0] csr_wr_data
);

   localparam int CW = $clog2(MAX_GROUP + 1);

   // command bundle from controller, held count back from datapath
   sgr_cmd_type   cmd;
   logic [CW-1:0] held_count;

   // state machine: collect requests, then walk the store one result at a time
   sgr_controller #(
      .MAX_GROUP (MAX_GROUP)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_last    (req_payload.in_last),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .held_count  (held_count),
      .cmd         (cmd)
   );

   // store, pointer and registered output; the output register holds while stalled
   sgr_datapath #(
      .MAX_GROUP (MAX_GROUP)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .held_count  (held_count),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

// ----- test/stream_group_reverser_tb.sv -----
// testbench for the stream group reverser: directed table, random streams, self-checking
`default_nettype none

module stream_group_reverser_tb;
   import sgr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_GROUP = SGR_MAX_GROUP;
   localparam int NUM_PHASES = 10;
   localparam int REQS_PER_PHASE = 36;
   localparam int SETTLE_CYCLES = 4;      // covers the result latency with margin
   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT = 600_000;

   // a row of the directed table either writes the group size or sends a request
   typedef enum bit {
      ROW_CFG,
      ROW_REQ
   } row_kind_type;

   typedef struct packed {
      row_kind_type           kind;
      logic [SGR_GSIZE_W-1:0] gsize;      // with ROW_CFG
      sgr_req_type            req;        // with ROW_REQ
      bit                     typed;      // first result typed in below
      sgr_rsp_type            first_rsp;
   } plan_row_type;

   localparam int PLAN_ROWS = 29;

   // dut ports; the inputs are all known from time zero
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   sgr_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   sgr_rsp_type rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic [SGR_GSIZE_W-1:0] csr_wr_data = '0;

   // model of the block: held values, their count and the group size register
   logic [SGR_VALUE_W-1:0] held_values [MAX_GROUP];
   int unsigned            held_count = 0;
   logic [SGR_GSIZE_W-1:0] group_size = SGR_GSIZE_RESET;

   // values the block still owes us, in output order
   sgr_rsp_type outgoing_order [$];
   int unsigned fails = 0;

   // quiet stretches: no idle cycles on that side
   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;

   logic [SGR_GSIZE_W-1:0] phase_sizes [NUM_PHASES] = '{
      5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd5, 5'd3, 5'd2, 5'd7, 5'd12
   };

   // directed table, after reset the group size is 2
   plan_row_type plan [PLAN_ROWS] = '{
      // pair of extremes, reversed
      '{ROW_REQ, 5'd0, '{32'h7FFF_FFFF, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h8000_0000, 1'b0}, 1'b1, '{32'h8000_0000, 1'b0, 1'b0}},
      // short tail at end of stream comes out as is
      '{ROW_REQ, 5'd0, '{32'h0000_0000, 1'b1}, 1'b1, '{32'h0000_0000, 1'b1, 1'b1}},
      '{ROW_REQ, 5'd0, '{32'hFFFF_FFFF, 1'b1}, 1'b1, '{32'hFFFF_FFFF, 1'b1, 1'b1}},
      // group of one passes straight through
      '{ROW_CFG, 5'd1, '{32'h0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0000_0005, 1'b0}, 1'b1, '{32'h0000_0005, 1'b1, 1'b0}},
      // zero size acts as one
      '{ROW_CFG, 5'd0, '{32'h0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h1234_5678, 1'b1}, 1'b1, '{32'h1234_5678, 1'b1, 1'b1}},
      // oversize saturates to a full group, which closes on the last request
      '{ROW_CFG, 5'd31, '{32'h0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0000_0001, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h5555_5555, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hAAAA_AAAA, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0F0F_0F0F, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hF0F0_F0F0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h00FF_00FF, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hFF00_FF00, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h3333_3333, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hCCCC_CCCC, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h8000_0001, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h7FFF_FFFE, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hDEAD_BEEF, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0000_FFFF, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hFFFF_0000, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h1111_1111, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'hEEEE_EEEE, 1'b1}, 1'b1, '{32'hEEEE_EEEE, 1'b0, 1'b0}},
      // shrink the group while two values are held: three come out reversed
      '{ROW_CFG, 5'd5, '{32'h0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0000_00A1, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_REQ, 5'd0, '{32'h0000_00A2, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}},
      '{ROW_CFG, 5'd2, '{32'h0, 1'b0}, 1'b0, '{32'h0, 1'b0, 1'b0}}
   };

   stream_group_reverser uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // idle cycles before the next handshake on one side
   function automatic int unsigned draw_gap(input bit calm);
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // mostly random words, now and then a corner value
   function automatic logic [SGR_VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // store one request and queue whatever run it releases
   task automatic reorder_request(input sgr_req_type r, input bit typed,
                                  input sgr_rsp_type typed_rsp);
      int unsigned k;
      int unsigned n;
      int unsigned i;
      bit          full;
      sgr_rsp_type rsp;
      k = (group_size == 0) ? 1 : ((group_size > MAX_GROUP) ? MAX_GROUP : group_size);
      if (held_count < MAX_GROUP) begin
         held_values[held_count] = r.in_value;
         held_count++;
      end
      n = held_count;
      full = (n >= k);
      if (full || r.in_last) begin
         for (i = 0; i < n; i++) begin
            // a full group comes out newest first, a short tail oldest first
            rsp.out_value = full ? held_values[n - 1 - i] : held_values[i];
            rsp.run_end = (i + 1 == n);
            rsp.stream_end = (i + 1 == n) && r.in_last;
            if (typed && i == 0) begin
               rsp = typed_rsp;
            end
            outgoing_order.push_back(rsp);
         end
         held_count = 0;
      end
   endtask

   // offer one request after a random gap and hold it until taken
   task automatic send_request(input sgr_req_type r, input bit typed,
                               input sgr_rsp_type typed_rsp);
      int unsigned gap;
      gap = draw_gap(req_calm);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall !== 1'b0);
      reorder_request(r, typed, typed_rsp);
   endtask

   // let every owed value arrive, then give the block time to go quiet
   task automatic settle_block();
      req_valid <= 1'b0;
      while (outgoing_order.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_group_size(input logic [SGR_GSIZE_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      group_size = value;
   endtask

   // result side: random stall per result, with quiet stretches
   initial begin : rsp_side
      int unsigned gap;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_calm);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // every result taken is compared with the oldest owed value
   always @(posedge clock) begin
      sgr_rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (outgoing_order.size() == 0) begin
            $error("unexpected result: out_value %h run_end %b stream_end %b",
                   rsp_payload.out_value, rsp_payload.run_end, rsp_payload.stream_end);
            fails++;
         end else begin
            want = outgoing_order.pop_front();
            if (rsp_payload.out_value !== want.out_value) begin
               $error("out_value: expected %h, got %h", want.out_value, rsp_payload.out_value);
               fails++;
            end
            if (rsp_payload.run_end !== want.run_end) begin
               $error("run_end: expected %b, got %b", want.run_end, rsp_payload.run_end);
               fails++;
            end
            if (rsp_payload.stream_end !== want.stream_end) begin
               $error("stream_end: expected %b, got %b", want.stream_end,
                      rsp_payload.stream_end);
               fails++;
            end
         end
      end
   end

   // hard stop if the block hangs
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("status: fail");
      $finish;
   end

   initial begin : stimulus
      int unsigned row;
      int unsigned ph;
      int unsigned j;
      int unsigned left_in_stream;
      sgr_req_type r;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (row = 0; row < PLAN_ROWS; row++) begin
         if (plan[row].kind == ROW_CFG) begin
            settle_block();
            write_group_size(plan[row].gsize);
         end else begin
            send_request(plan[row].req, plan[row].typed, plan[row].first_rsp);
         end
      end
      // the shrunk group is released by this request
      r.in_value = 32'h0000_00A3;
      r.in_last = 1'b0;
      send_request(r, 1'b1, '{32'h0000_00A3, 1'b0, 1'b0});

      // random streams, one group size per phase; a stream may run across
      // a phase change so values stay held while the size moves
      left_in_stream = 0;
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         settle_block();
         write_group_size(phase_sizes[ph]);
         req_calm = (ph % 3 == 1);
         rsp_calm = (ph % 4 == 2);
         for (j = 0; j < REQS_PER_PHASE; j++) begin
            if (left_in_stream == 0) begin
               left_in_stream = $urandom_range(1, 40);
            end
            left_in_stream--;
            r.in_value = pick_value();
            r.in_last = (left_in_stream == 0) ||
                        (ph == NUM_PHASES - 1 && j == REQS_PER_PHASE - 1);
            if (r.in_last) begin
               left_in_stream = 0;
            end
            send_request(r, 1'b0, '0);
         end
      end

      // drain and look for anything still owed
      req_valid <= 1'b0;
      while (outgoing_order.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (outgoing_order.size() != 0) begin
         $error("%0d results never arrived", outgoing_order.size());
         fails++;
      end
      if (fails == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/sgr_pkg.sv
rtl/sgr_datapath.sv
rtl/sgr_controller.sv
rtl/stream_group_reverser.sv
test/stream_group_reverser_tb.sv
